// File: hdl/agcc_pkg.sv
// ----------------------------------------------------------------------------
// agcc_pkg
// Shared types, constants and tables of the asymmetric Gaussian cell cost
// pipeline.
// ----------------------------------------------------------------------------
package agcc_pkg;

    // Stage counts of the iterative units.
    localparam int CORDIC_STEPS = 16;
    localparam int QUOT_STEPS   = 20;
    localparam int EXP_STEPS    = 20;

    // Width of numerators, denominators and remainders in the divider.
    localparam int NUM_W = 52;

    // Angle constants in Q20 radians.
    localparam logic signed [23:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [23:0] TWO_PI_Q20  = 24'sd6588397;
    localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;

    // Reciprocal of the CORDIC gain, Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    // Saturated exponent, 16.0 in Q16.
    localparam logic [20:0] Q16_CAP = 21'd1048576;

    // Arctangent of 2^-i in Q20 radians.
    localparam logic signed [23:0] ATAN_Q20 [0:CORDIC_STEPS-1] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32
    };

    // exp(-w) in Q32 for w = 8, 4, 2, 1, 1/2, ..., 2^-16.
    localparam logic [31:0] EXP_Q32 [0:EXP_STEPS-1] = '{
        32'd1440801,    32'd78665070,   32'd581260615,  32'd1580030168,
        32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
        32'd4162825044, 32'd4228379999, 32'd4261543595, 32'd4278222805,
        32'd4286586874, 32'd4290775039, 32'd4292870655, 32'd4293918847,
        32'd4294443039, 32'd4294705159, 32'd4294836225, 32'd4294901760
    };

    // Register indexes of the configuration port.
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_ENABLE  = 3'd0;
    localparam reg_idx_t REG_CUTOFF  = 3'd1;
    localparam reg_idx_t REG_PEAK    = 3'd2;
    localparam reg_idx_t REG_BASEVAR = 3'd3;
    localparam reg_idx_t REG_GAIN    = 3'd4;

    // Data that rides along with every item.
    typedef struct packed {
        logic       pass;
        logic [7:0] prior_cost;
    } side_t;

    // Sideband of the rotator: squares of the offset and the forward variance.
    typedef struct packed {
        side_t       side;
        logic [49:0] dxx;
        logic [49:0] dyy;
        logic [48:0] varx;
    } rot_side_t;

    // One lane of one divider stage.
    typedef struct packed {
        logic             sat;
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] d;
        logic [19:0]      q;
    } quot_lane_t;

endpackage

// File: hdl/agcc_rotate.sv
// ----------------------------------------------------------------------------
// agcc_rotate
// Pipelined CORDIC rotator, one micro-rotation per stage, followed by two
// stages that remove the CORDIC gain.
// ----------------------------------------------------------------------------
module agcc_rotate (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [31:0]     x_in,
    input  logic signed [31:0]     y_in,
    input  logic signed [23:0]     z_in,
    input  agcc_pkg::rot_side_t    side_in,
    output logic                   out_valid,
    output logic signed [26:0]     mx,
    output logic signed [26:0]     my,
    output agcc_pkg::rot_side_t    side_out
);

    localparam int N = agcc_pkg::CORDIC_STEPS;

    logic signed [31:0]  x_reg    [0:N-1];
    logic signed [31:0]  y_reg    [0:N-1];
    logic signed [23:0]  z_reg    [0:N-2];
    logic                v_reg    [0:N+1];
    agcc_pkg::rot_side_t side_reg [0:N+1];

    logic signed [46:0] xh_prod_reg;
    logic signed [46:0] yh_prod_reg;
    logic [45:0]        xl_prod_reg;
    logic [45:0]        yl_prod_reg;
    logic signed [26:0] mx_reg;
    logic signed [26:0] my_reg;
    logic signed [63:0] xfull;
    logic signed [63:0] yfull;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            logic signed [31:0]  xp;
            logic signed [31:0]  yp;
            logic signed [23:0]  zp;
            logic                vp;
            agcc_pkg::rot_side_t sp;
            logic signed [31:0]  xn;
            logic signed [31:0]  yn;
            logic                dir;

            if (i == 0) begin : g_first
                assign xp = x_in;
                assign yp = y_in;
                assign zp = z_in;
                assign vp = in_valid;
                assign sp = side_in;
            end else begin : g_later
                assign xp = x_reg[i-1];
                assign yp = y_reg[i-1];
                assign zp = z_reg[i-1];
                assign vp = v_reg[i-1];
                assign sp = side_reg[i-1];
            end

            // One micro-rotation toward zero residual angle.
            always_comb
            begin
                dir = (zp >= 0);
                if (dir)
                begin
                    xn = xp + (yp >>> i);
                    yn = yp - (xp >>> i);
                end
                else
                begin
                    xn = xp - (yp >>> i);
                    yn = yp + (xp >>> i);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= vp;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]    <= xn;
                    y_reg[i]    <= yn;
                    side_reg[i] <= sp;
                end
            end

            // The last step leaves no residual angle behind.
            if (i < N - 1) begin : g_z
                always_ff @(posedge clk)
                begin
                    if (en)
                        z_reg[i] <= dir ? zp - agcc_pkg::ATAN_Q20[i]
                                        : zp + agcc_pkg::ATAN_Q20[i];
                end
            end
        end
    endgenerate

    // Gain removal, first stage: partial products of the upper and lower halves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xh_prod_reg  <= $signed(x_reg[N-1][31:16]) * $signed({1'b0, agcc_pkg::INV_GAIN_Q30});
            yh_prod_reg  <= $signed(y_reg[N-1][31:16]) * $signed({1'b0, agcc_pkg::INV_GAIN_Q30});
            xl_prod_reg  <= x_reg[N-1][15:0] * agcc_pkg::INV_GAIN_Q30;
            yl_prod_reg  <= y_reg[N-1][15:0] * agcc_pkg::INV_GAIN_Q30;
            side_reg[N]  <= side_reg[N-1];
        end
    end

    // Gain removal, second stage: combine the partial products and floor.
    always_comb
    begin
        xfull = ($signed({{17{xh_prod_reg[46]}}, xh_prod_reg}) <<< 16)
              + $signed({18'd0, xl_prod_reg});
        yfull = ($signed({{17{yh_prod_reg[46]}}, yh_prod_reg}) <<< 16)
              + $signed({18'd0, yl_prod_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg        <= xfull[60:34];
            my_reg        <= yfull[60:34];
            side_reg[N+1] <= side_reg[N];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[N]   <= 1'b0;
            v_reg[N+1] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[N]   <= v_reg[N-1];
            v_reg[N+1] <= v_reg[N];
        end
    end

    assign out_valid = v_reg[N+1];
    assign mx        = mx_reg;
    assign my        = my_reg;
    assign side_out  = side_reg[N+1];

endmodule

// File: hdl/agcc_quot.sv
// ----------------------------------------------------------------------------
// agcc_quot
// Two-lane pipelined restoring divider: floor(n * 2^20 / d) in Q16,
// saturated at 16.0, one quotient bit per stage.
// ----------------------------------------------------------------------------
module agcc_quot (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [agcc_pkg::NUM_W-1:0]  n_a,
    input  logic [agcc_pkg::NUM_W-1:0]  d_a,
    input  logic [agcc_pkg::NUM_W-1:0]  n_b,
    input  logic [agcc_pkg::NUM_W-1:0]  d_b,
    input  agcc_pkg::side_t             side_in,
    output logic                        out_valid,
    output logic [20:0]                 q_a,
    output logic [20:0]                 q_b,
    output agcc_pkg::side_t             side_out
);

    localparam int S = agcc_pkg::QUOT_STEPS;

    agcc_pkg::quot_lane_t lane_reg [0:S][0:1];
    logic                 v_reg    [0:S];
    agcc_pkg::side_t      side_reg [0:S];
    logic [agcc_pkg::NUM_W-1:0] n_in [0:1];
    logic [agcc_pkg::NUM_W-1:0] d_in [0:1];

    assign n_in[0] = n_a;
    assign n_in[1] = n_b;
    assign d_in[0] = d_a;
    assign d_in[1] = d_b;

    genvar s, l;
    generate
        // Entry stage: a numerator not below the denominator saturates.
        for (l = 0; l < 2; l++) begin : g_entry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lane_reg[0][l].sat <= (n_in[l] >= d_in[l]);
                    lane_reg[0][l].r   <= n_in[l];
                    lane_reg[0][l].d   <= d_in[l];
                    lane_reg[0][l].q   <= '0;
                end
            end
        end

        // One shift, compare and subtract per stage and lane.
        for (s = 1; s <= S; s++) begin : g_step
            for (l = 0; l < 2; l++) begin : g_lane
                logic [agcc_pkg::NUM_W-1:0] r2;
                agcc_pkg::quot_lane_t       nxt;

                always_comb
                begin
                    nxt = lane_reg[s-1][l];
                    r2  = {lane_reg[s-1][l].r[agcc_pkg::NUM_W-2:0], 1'b0};
                    if (r2 >= lane_reg[s-1][l].d)
                    begin
                        nxt.r = r2 - lane_reg[s-1][l].d;
                        nxt.q = {lane_reg[s-1][l].q[18:0], 1'b1};
                    end
                    else
                    begin
                        nxt.r = r2;
                        nxt.q = {lane_reg[s-1][l].q[18:0], 1'b0};
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                        lane_reg[s][l] <= nxt;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[s] <= side_reg[s-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else if (en)
                    v_reg[s] <= v_reg[s-1];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            side_reg[0] <= side_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    assign out_valid = v_reg[S];
    assign side_out  = side_reg[S];
    assign q_a = lane_reg[S][0].sat ? agcc_pkg::Q16_CAP : {1'b0, lane_reg[S][0].q};
    assign q_b = lane_reg[S][1].sat ? agcc_pkg::Q16_CAP : {1'b0, lane_reg[S][1].q};

endmodule

// File: hdl/agcc_exp.sv
// ----------------------------------------------------------------------------
// agcc_exp
// Pipelined exp(-e) as a product of constants over the bits of e, then the
// amplitude scaling, the cutoff test and the merge with the old cost.
// ----------------------------------------------------------------------------
module agcc_exp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [19:0]     e_in,
    input  logic            sat_in,
    input  agcc_pkg::side_t side_in,
    input  logic [15:0]     peak,
    input  logic [15:0]     cutoff,
    output logic            out_valid,
    output logic [7:0]      new_cost,
    output logic            raised
);

    localparam int K = agcc_pkg::EXP_STEPS;

    logic [32:0]     acc_reg  [0:K-1];
    logic [19:0]     e_reg    [0:K-2];
    logic            v_reg    [0:K+1];
    agcc_pkg::side_t side_reg [0:K];

    logic [15:0] val_reg;
    logic [48:0] amp;
    logic [7:0]  cost_reg;
    logic        raised_reg;
    logic [7:0]  cost;

    genvar k;
    generate
        for (k = 0; k < K; k++) begin : g_step
            logic [32:0] acc_n;

            if (k == 0) begin : g_first
                // The product starts at one, at exp(-8) when the top bit of e is set, or at zero when e saturated.
                always_comb
                begin
                    if (sat_in)
                        acc_n = '0;
                    else if (e_in[19])
                        acc_n = {1'b0, agcc_pkg::EXP_Q32[0]};
                    else
                        acc_n = 33'h1_0000_0000;
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        e_reg[0]    <= e_in;
                        side_reg[0] <= side_in;
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[0] <= 1'b0;
                    else if (en)
                        v_reg[0] <= in_valid;
                end
            end else begin : g_later
                logic [63:0] prod;
                logic [32:0] stepped;

                // Multiply by exp(-weight) where this bit of e is set.
                always_comb
                begin
                    prod = acc_reg[k-1][31:0] * agcc_pkg::EXP_Q32[k];
                    if (acc_reg[k-1][32])
                        stepped = {1'b0, agcc_pkg::EXP_Q32[k]};
                    else
                        stepped = {1'b0, prod[63:32]};
                    acc_n = e_reg[k-1][K-1-k] ? stepped : acc_reg[k-1];
                end

                if (k < K - 1) begin : g_e
                    always_ff @(posedge clk)
                    begin
                        if (en)
                            e_reg[k] <= e_reg[k-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                        side_reg[k] <= side_reg[k-1];
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[k] <= 1'b0;
                    else if (en)
                        v_reg[k] <= v_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    acc_reg[k] <= acc_n;
            end
        end
    endgenerate

    // Amplitude scaling.
    assign amp = {33'd0, peak} * {16'd0, acc_reg[K-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg     <= amp[47:32];
            side_reg[K] <= side_reg[K-1];
        end
    end

    // Cutoff test and merge with the old cost.
    assign cost = val_reg[15:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!side_reg[K].pass && val_reg >= cutoff)
            begin
                raised_reg <= 1'b1;
                cost_reg   <= (cost > side_reg[K].prior_cost) ? cost
                                                              : side_reg[K].prior_cost;
            end
            else
            begin
                raised_reg <= 1'b0;
                cost_reg   <= side_reg[K].prior_cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[K]   <= 1'b0;
            v_reg[K+1] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[K]   <= v_reg[K-1];
            v_reg[K+1] <= v_reg[K];
        end
    end

    assign out_valid = v_reg[K+1];
    assign new_cost  = cost_reg;
    assign raised    = raised_reg;

endmodule

// File: hdl/asymmetric_gaussian_cell_cost.sv
// ----------------------------------------------------------------------------
// asymmetric_gaussian_cell_cost
// Raises a map cell's cost with an asymmetric Gaussian around one station.
// ----------------------------------------------------------------------------
// Usage:
// Cell requests enter on the s_ side, one per cycle while s_tready is high;
// each carries the cell centre, the station centre, heading and magnitude,
// and the old cost. Every request gives exactly one result on the m_ side,
// in order: the new cost in m_tdata and the raised flag in m_tuser.
// Throughput is one request per cycle while the output is not stalled, since
// every CORDIC micro-rotation, every divider bit and every exp factor has a
// pipeline stage of its own.
// When the receiver stalls, the output register holds its result and one
// more result moves into a skid register; then s_tready drops and the whole
// pipeline freezes until the output is taken. Nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults. The user must
// write registers over the APB port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module asymmetric_gaussian_cell_cost (
    input  logic         clk,
    input  logic         rst_n,
    // Cell requests.
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_x[23:0], cell_y[47:24], station_x[71:48], station_y[95:72],
    // heading[111:96], magnitude[127:112], prior_cost[135:128]
    input  logic [135:0] s_tdata,
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_cost[7:0]
    output logic [7:0]   m_tdata,
    // raised[0]
    output logic [0:0]   m_tuser,
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] cutoff_reg;
    logic [15:0] peak_reg;
    logic [15:0] basevar_reg;
    logic [15:0] gain_reg;
    logic [15:0] bvn;

    logic en;

    // Input fields.
    logic signed [23:0] cell_x, cell_y, station_x, station_y;
    logic signed [15:0] heading;
    logic [15:0]        magnitude;
    logic [7:0]         prior_cost;

    // First stage.
    logic               v1_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [23:0] z1_reg;
    logic [31:0]        mg_reg;
    agcc_pkg::side_t    side1_reg;
    logic signed [23:0] zh, zw;

    // Second stage.
    logic                v2_reg;
    logic signed [31:0]  x0_reg, y0_reg;
    logic signed [23:0]  z0_reg;
    agcc_pkg::rot_side_t rs2_reg;
    logic signed [31:0]  xs, ys, x0_next, y0_next;
    logic signed [23:0]  z0_next;
    logic signed [49:0]  dxx_full, dyy_full;
    logic [32:0]         fac;
    logic [48:0]         varx_next;

    // Rotator outputs.
    logic                rot_valid;
    logic signed [26:0]  mx, my;
    agcc_pkg::rot_side_t rot_side;

    // Square stage.
    logic                       vq_reg;
    logic [agcc_pkg::NUM_W-1:0] na_reg, da_reg, nb_reg, db_reg;
    agcc_pkg::side_t            sideq_reg;
    logic signed [53:0]         mxx_full, myy_full;
    logic [agcc_pkg::NUM_W-1:0] dsq, v0x2, dfront;
    logic                       front;

    // Divider outputs.
    logic            quot_valid;
    logic [20:0]     q_a, q_b;
    agcc_pkg::side_t quot_side;

    // Sum stage.
    logic            ve_reg;
    logic [19:0]     e_reg;
    logic            esat_reg;
    agcc_pkg::side_t sidee_reg;
    logic [21:0]     e_sum;

    // Exp outputs.
    logic       exp_valid;
    logic [7:0] exp_cost;
    logic       exp_raised;

    // Output and skid registers.
    logic       out_valid_reg, skid_valid_reg;
    logic [7:0] out_cost_reg, skid_cost_reg;
    logic       out_raised_reg, skid_raised_reg;
    logic       out_free;

    // The pipeline moves whenever the skid register is empty.
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign pready   = 1'b1;

    assign bvn = (basevar_reg == 16'd0) ? 16'd1 : basevar_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            cutoff_reg  <= 16'd2560;
            peak_reg    <= 16'd65024;
            basevar_reg <= 16'd64;
            gain_reg    <= 16'd256;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                agcc_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                agcc_pkg::REG_CUTOFF:  cutoff_reg  <= pwdata[15:0];
                agcc_pkg::REG_PEAK:    peak_reg    <= pwdata[15:0];
                agcc_pkg::REG_BASEVAR: basevar_reg <= pwdata[15:0];
                agcc_pkg::REG_GAIN:    gain_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            agcc_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            agcc_pkg::REG_CUTOFF:  prdata = {16'd0, cutoff_reg};
            agcc_pkg::REG_PEAK:    prdata = {16'd0, peak_reg};
            agcc_pkg::REG_BASEVAR: prdata = {16'd0, basevar_reg};
            agcc_pkg::REG_GAIN:    prdata = {16'd0, gain_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Unpack the request.
    assign cell_x     = s_tdata[23:0];
    assign cell_y     = s_tdata[47:24];
    assign station_x  = s_tdata[71:48];
    assign station_y  = s_tdata[95:72];
    assign heading    = s_tdata[111:96];
    assign magnitude  = s_tdata[127:112];
    assign prior_cost = s_tdata[135:128];

    // First stage: offsets, heading wrap and the magnitude-gain product.
    always_comb
    begin
        zh = $signed({heading[15], heading, 7'b0});
        if (zh > agcc_pkg::PI_Q20)
            zw = zh - agcc_pkg::TWO_PI_Q20;
        else if (zh < -agcc_pkg::PI_Q20)
            zw = zh + agcc_pkg::TWO_PI_Q20;
        else
            zw = zh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= $signed({cell_x[23], cell_x}) - $signed({station_x[23], station_x});
            dy_reg <= $signed({cell_y[23], cell_y}) - $signed({station_y[23], station_y});
            z1_reg <= zw;
            mg_reg <= magnitude * gain_reg;
            side1_reg.pass       <= !enable_reg || (cutoff_reg >= peak_reg)
                                    || (prior_cost == 8'hFF);
            side1_reg.prior_cost <= prior_cost;
        end
    end

    // Second stage: quarter turn into the CORDIC range, squares and variance.
    always_comb
    begin
        xs = {{3{dx_reg[24]}}, dx_reg, 4'b0};
        ys = {{3{dy_reg[24]}}, dy_reg, 4'b0};
        if (z1_reg > agcc_pkg::HALF_PI_Q20)
        begin
            x0_next = ys;
            y0_next = -xs;
            z0_next = z1_reg - agcc_pkg::HALF_PI_Q20;
        end
        else if (z1_reg < -agcc_pkg::HALF_PI_Q20)
        begin
            x0_next = -ys;
            y0_next = xs;
            z0_next = z1_reg + agcc_pkg::HALF_PI_Q20;
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            z0_next = z1_reg;
        end
        dxx_full  = dx_reg * dx_reg;
        dyy_full  = dy_reg * dy_reg;
        fac       = 33'h1_0000 + {1'b0, mg_reg};
        varx_next = {33'd0, bvn} * {16'd0, fac};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg       <= x0_next;
            y0_reg       <= y0_next;
            z0_reg       <= z0_next;
            rs2_reg.side <= side1_reg;
            rs2_reg.dxx  <= dxx_full;
            rs2_reg.dyy  <= dyy_full;
            rs2_reg.varx <= varx_next;
        end
    end

    agcc_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .x_in      (x0_reg),
        .y_in      (y0_reg),
        .z_in      (z0_reg),
        .side_in   (rs2_reg),
        .out_valid (rot_valid),
        .mx        (mx),
        .my        (my),
        .side_out  (rot_side)
    );

    // Square stage: pick numerators and denominators for the front or back.
    always_comb
    begin
        mxx_full = mx * mx;
        myy_full = my * my;
        dsq      = {2'b0, rot_side.dxx} + {2'b0, rot_side.dyy};
        v0x2     = {19'd0, bvn, 17'd0};
        dfront   = {2'b0, rot_side.varx, 1'b0};
        front    = (mx > 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg    <= front ? mxx_full[agcc_pkg::NUM_W-1:0] : dsq;
            da_reg    <= front ? dfront : v0x2;
            nb_reg    <= front ? myy_full[agcc_pkg::NUM_W-1:0] : '0;
            db_reg    <= v0x2;
            sideq_reg <= rot_side.side;
        end
    end

    agcc_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vq_reg),
        .n_a       (na_reg),
        .d_a       (da_reg),
        .n_b       (nb_reg),
        .d_b       (db_reg),
        .side_in   (sideq_reg),
        .out_valid (quot_valid),
        .q_a       (q_a),
        .q_b       (q_b),
        .side_out  (quot_side)
    );

    // Sum stage: exponent with saturation at 16.0.
    assign e_sum = {1'b0, q_a} + {1'b0, q_b};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg     <= e_sum[19:0];
            esat_reg  <= e_sum[21] | e_sum[20];
            sidee_reg <= quot_side;
        end
    end

    agcc_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ve_reg),
        .e_in      (e_reg),
        .sat_in    (esat_reg),
        .side_in   (sidee_reg),
        .peak      (peak_reg),
        .cutoff    (cutoff_reg),
        .out_valid (exp_valid),
        .new_cost  (exp_cost),
        .raised    (exp_raised)
    );

    // Valid bits of the stages in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vq_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            vq_reg <= rot_valid;
            ve_reg <= quot_valid;
        end
    end

    // Output register with a skid register behind it.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= exp_valid;
        end
        else if (exp_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_cost_reg   <= skid_cost_reg;
                out_raised_reg <= skid_raised_reg;
            end
            else
            begin
                out_cost_reg   <= exp_cost;
                out_raised_reg <= exp_raised;
            end
        end
        else if (en)
        begin
            skid_cost_reg   <= exp_cost;
            skid_raised_reg <= exp_raised;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_cost_reg;
    assign m_tuser[0] = out_raised_reg;

endmodule

// File: hdl/agcc_checker.sv
// ----------------------------------------------------------------------------
// agcc_checker
// Port-level checks of the cell cost block's flow control, bound to the top.
// ----------------------------------------------------------------------------
module agcc_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // A result on offer stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // Requests are refused only after the output has been stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("request refused without an output stall");

    // A refused request means a result waits at the output.
    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("request refused while the output is empty");

    // The stall persists while the output is not taken.
    a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tvalid && !m_tready |=> !s_tready)
        else $error("pipeline restarted while the output was stalled");

endmodule

bind asymmetric_gaussian_cell_cost agcc_checker u_agcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
